/* rtl/mbtl_pkg.sv */
// shared constants, command codes and control structs of the mipmap lookup unit
package mbtl_pkg;

	// default sizes
	localparam int DEF_LOG_MAX_SIDE = 8;
	localparam int DEF_TEXEL_BITS = 16;

	// fixed field widths
	localparam int COORD_W = 20;
	localparam int TEXIN_W = 16;
	localparam int OUT_W = 16;
	localparam int CFG_W = 4;
	localparam int CFG_IDX_W = 2;
	localparam int LEVEL_W = 4;
	localparam int FRAC_W = 16;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WRAP = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LOG_W = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LOG_H = 2'd2;

	// wrap codes, anything else means black
	localparam logic [1:0] WRAP_REPEAT = 2'd0;
	localparam logic [1:0] WRAP_CLAMP = 2'd1;

	// operations
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	// datapath commands
	localparam int CMD_W = 5;
	localparam logic [CMD_W-1:0] CMD_NOP = 5'd0;
	localparam logic [CMD_W-1:0] CMD_LOAD = 5'd1;
	localparam logic [CMD_W-1:0] CMD_LATCH = 5'd2;
	localparam logic [CMD_W-1:0] CMD_ZERO = 5'd3;
	localparam logic [CMD_W-1:0] CMD_B_INIT = 5'd4;
	localparam logic [CMD_W-1:0] CMD_B_LVL = 5'd5;
	localparam logic [CMD_W-1:0] CMD_B_RD = 5'd6;
	localparam logic [CMD_W-1:0] CMD_B_WR = 5'd7;
	localparam logic [CMD_W-1:0] CMD_L_MAX = 5'd8;
	localparam logic [CMD_W-1:0] CMD_L_LVL = 5'd9;
	localparam logic [CMD_W-1:0] CMD_L_POS = 5'd10;
	localparam logic [CMD_W-1:0] CMD_L_RD = 5'd11;
	localparam logic [CMD_W-1:0] CMD_L_CAP = 5'd12;
	localparam logic [CMD_W-1:0] CMD_LR0 = 5'd13;
	localparam logic [CMD_W-1:0] CMD_LR1 = 5'd14;
	localparam logic [CMD_W-1:0] CMD_LR2 = 5'd15;
	localparam logic [CMD_W-1:0] CMD_NEXT = 5'd16;
	localparam logic [CMD_W-1:0] CMD_BLEND = 5'd17;
	localparam logic [CMD_W-1:0] CMD_TOP = 5'd18;
	localparam logic [CMD_W-1:0] CMD_TOPC = 5'd19;
	localparam logic [CMD_W-1:0] CMD_OUT = 5'd20;

	typedef struct packed {
		logic [CMD_W-1:0] code;
		logic restart;
	} cmd_t;

	typedef struct packed {
		logic last_load;
		logic one_level;
		logic k_last;
		logic tex_last;
		logic lvl_last;
		logic mode_top;
		logic mode_blend;
		logic which;
	} status_t;

	// entries of a full pyramid with base side 2^lg, plus one
	function automatic int store_depth(input int lg);
		return ((1 << (2 * lg + 2)) - 1) / 3 + 1;
	endfunction

	// log2 of a level side, floor of one texel
	function automatic logic [LEVEL_W-1:0] side_log(input logic [LEVEL_W-1:0] lg,
			input logic [LEVEL_W-1:0] lvl);
		return (lg > lvl) ? lg - lvl : '0;
	endfunction

endpackage

/* rtl/mbtl_ctrl.sv */
// controller state machine: handshakes, build sequencing and lookup sequencing
module mbtl_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic op,
	output logic out_valid,
	input  logic out_stall,
	input  logic cfg_we,
	input  logic [mbtl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  mbtl_pkg::status_t st,
	output mbtl_pkg::cmd_t cmd
);

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_B_INIT = 5'd1;
	localparam logic [4:0] S_B_LVL = 5'd2;
	localparam logic [4:0] S_B_RD = 5'd3;
	localparam logic [4:0] S_B_WR = 5'd4;
	localparam logic [4:0] S_L_MAX = 5'd5;
	localparam logic [4:0] S_L_LVL = 5'd6;
	localparam logic [4:0] S_L_SEL = 5'd7;
	localparam logic [4:0] S_L_POS = 5'd8;
	localparam logic [4:0] S_L_RD = 5'd9;
	localparam logic [4:0] S_L_CAP = 5'd10;
	localparam logic [4:0] S_LR0 = 5'd11;
	localparam logic [4:0] S_LR1 = 5'd12;
	localparam logic [4:0] S_LR2 = 5'd13;
	localparam logic [4:0] S_NEXT = 5'd14;
	localparam logic [4:0] S_BLEND = 5'd15;
	localparam logic [4:0] S_TOP = 5'd16;
	localparam logic [4:0] S_TOPC = 5'd17;
	localparam logic [4:0] S_ZERO = 5'd18;
	localparam logic [4:0] S_FIN = 5'd19;

	logic [4:0] state_q, state_d;
	logic ready_q, ready_d;
	logic out_valid_q, out_valid_d;

	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	// next state and commands
	always_comb begin
		state_d = state_q;
		ready_d = ready_q;
		out_valid_d = out_valid_q;
		cmd.code = mbtl_pkg::CMD_NOP;
		cmd.restart = ready_q;
		if (out_valid_q && !out_stall) begin
			out_valid_d = 1'b0;
		end
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (op == mbtl_pkg::OP_LOAD) begin
						cmd.code = mbtl_pkg::CMD_LOAD;
						ready_d = 1'b0;
						if (st.last_load) begin
							state_d = S_B_INIT;
						end
					end else begin
						cmd.code = mbtl_pkg::CMD_LATCH;
						state_d = ready_q ? S_L_MAX : S_ZERO;
					end
				end
			end
			S_B_INIT: begin
				cmd.code = mbtl_pkg::CMD_B_INIT;
				if (st.one_level) begin
					ready_d = 1'b1;
					state_d = S_IDLE;
				end else begin
					state_d = S_B_LVL;
				end
			end
			S_B_LVL: begin
				cmd.code = mbtl_pkg::CMD_B_LVL;
				state_d = S_B_RD;
			end
			S_B_RD: begin
				cmd.code = mbtl_pkg::CMD_B_RD;
				if (st.k_last) begin
					state_d = S_B_WR;
				end
			end
			S_B_WR: begin
				cmd.code = mbtl_pkg::CMD_B_WR;
				if (st.tex_last && st.lvl_last) begin
					ready_d = 1'b1;
					state_d = S_IDLE;
				end else if (st.tex_last) begin
					state_d = S_B_LVL;
				end else begin
					state_d = S_B_RD;
				end
			end
			S_L_MAX: begin
				cmd.code = mbtl_pkg::CMD_L_MAX;
				state_d = S_L_LVL;
			end
			S_L_LVL: begin
				cmd.code = mbtl_pkg::CMD_L_LVL;
				state_d = S_L_SEL;
			end
			S_L_SEL: begin
				state_d = st.mode_top ? S_TOP : S_L_POS;
			end
			S_L_POS: begin
				cmd.code = mbtl_pkg::CMD_L_POS;
				state_d = S_L_RD;
			end
			S_L_RD: begin
				cmd.code = mbtl_pkg::CMD_L_RD;
				if (st.k_last) begin
					state_d = S_L_CAP;
				end
			end
			S_L_CAP: begin
				cmd.code = mbtl_pkg::CMD_L_CAP;
				state_d = S_LR0;
			end
			S_LR0: begin
				cmd.code = mbtl_pkg::CMD_LR0;
				state_d = S_LR1;
			end
			S_LR1: begin
				cmd.code = mbtl_pkg::CMD_LR1;
				state_d = S_LR2;
			end
			S_LR2: begin
				cmd.code = mbtl_pkg::CMD_LR2;
				if (st.mode_blend && !st.which) begin
					state_d = S_NEXT;
				end else if (st.mode_blend) begin
					state_d = S_BLEND;
				end else begin
					state_d = S_FIN;
				end
			end
			S_NEXT: begin
				cmd.code = mbtl_pkg::CMD_NEXT;
				state_d = S_L_POS;
			end
			S_BLEND: begin
				cmd.code = mbtl_pkg::CMD_BLEND;
				state_d = S_FIN;
			end
			S_TOP: begin
				cmd.code = mbtl_pkg::CMD_TOP;
				state_d = S_TOPC;
			end
			S_TOPC: begin
				cmd.code = mbtl_pkg::CMD_TOPC;
				state_d = S_FIN;
			end
			S_ZERO: begin
				cmd.code = mbtl_pkg::CMD_ZERO;
				state_d = S_FIN;
			end
			S_FIN: begin
				if (!out_valid_q || !out_stall) begin
					cmd.code = mbtl_pkg::CMD_OUT;
					out_valid_d = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		// a size change drops the pyramid
		if (cfg_we && (cfg_index == mbtl_pkg::REG_LOG_W || cfg_index == mbtl_pkg::REG_LOG_H)) begin
			ready_d = 1'b0;
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ready_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ready_q <= ready_d;
			out_valid_q <= out_valid_d;
		end
	end

endmodule

/* rtl/mbtl_dp.sv */
// datapath: config registers, pyramid memory, texel fetch, level math and lerp unit
module mbtl_dp #(
	parameter int LOG_MAX_SIDE = mbtl_pkg::DEF_LOG_MAX_SIDE,
	parameter int TEXEL_BITS = mbtl_pkg::DEF_TEXEL_BITS
) (
	input  logic clk,
	input  logic arst_n,
	input  mbtl_pkg::cmd_t cmd,
	output mbtl_pkg::status_t st,
	input  logic cfg_we,
	input  logic [mbtl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mbtl_pkg::CFG_W-1:0] cfg_data,
	input  logic [mbtl_pkg::TEXIN_W-1:0] texel_value,
	input  logic signed [mbtl_pkg::COORD_W-1:0] s_coord,
	input  logic signed [mbtl_pkg::COORD_W-1:0] t_coord,
	input  logic signed [mbtl_pkg::COORD_W-1:0] ds_dx,
	input  logic signed [mbtl_pkg::COORD_W-1:0] dt_dx,
	input  logic signed [mbtl_pkg::COORD_W-1:0] ds_dy,
	input  logic signed [mbtl_pkg::COORD_W-1:0] dt_dy,
	output logic [mbtl_pkg::OUT_W-1:0] filtered_value
);

	localparam int L = LOG_MAX_SIDE;
	localparam int TW = TEXEL_BITS;
	localparam int DEPTH = mbtl_pkg::store_depth(L);
	localparam int AW = $clog2(DEPTH);
	localparam int LW = $clog2(L + 1);
	localparam int CW = L + 5;
	localparam int XW = mbtl_pkg::COORD_W + L + 1;
	localparam int VW = LW + 13;
	localparam int LVW = mbtl_pkg::LEVEL_W;
	localparam int FW = mbtl_pkg::FRAC_W;
	localparam int HALF = 32768;
	localparam int LV_BIAS = 4096;
	localparam int WW = mbtl_pkg::COORD_W;

	// configuration
	logic [1:0] wrap_q;
	logic [LVW-1:0] lbw_q, lbh_q;
	logic [LVW-1:0] lgw, lgh, top;
	logic [AW:0] total;
	logic [AW-1:0] cnt_q;

	assign lgw = (lbw_q > LVW'(L)) ? LVW'(L) : lbw_q;
	assign lgh = (lbh_q > LVW'(L)) ? LVW'(L) : lbh_q;
	assign top = (lgw > lgh) ? lgw : lgh;
	assign total = (AW + 1)'(1) << ((LVW + 1)'(lgw) + (LVW + 1)'(lgh));

	// load address
	logic [AW-1:0] ld_addr;
	assign ld_addr = cmd.restart ? '0 : cnt_q;
	assign st.last_load = (({1'b0, ld_addr} + (AW + 1)'(1)) == total);
	assign st.one_level = (top == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wrap_q <= mbtl_pkg::WRAP_REPEAT;
			lbw_q <= 4'd8;
			lbh_q <= 4'd8;
			cnt_q <= '0;
		end else begin
			if (cmd.code == mbtl_pkg::CMD_LOAD) begin
				cnt_q <= st.last_load ? '0 : ld_addr + AW'(1);
			end
			if (cfg_we) begin
				case (cfg_index)
					mbtl_pkg::REG_WRAP: begin
						wrap_q <= cfg_data[1:0];
					end
					mbtl_pkg::REG_LOG_W: begin
						lbw_q <= cfg_data;
						cnt_q <= '0;
					end
					mbtl_pkg::REG_LOG_H: begin
						lbh_q <= cfg_data;
						cnt_q <= '0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// working registers
	logic [AW-1:0] lb_q [L+1];
	logic [LVW-1:0] blvl_q, cur_lvl_q;
	logic [L-1:0] bs_q, bt_q;
	logic [1:0] k_q;
	logic [TW+1:0] acc_q;
	logic [AW-1:0] wptr_q;
	logic signed [WW-1:0] sc_q, tc_q;
	logic signed [WW-1:0] der_q [4];
	logic [WW-1:0] wmax_q;
	logic mode_top_q, mode_blend_q, which_q;
	logic [7:0] d_q;
	logic signed [CW-1:0] ix_q, iy_q;
	logic [FW-1:0] fx_q, fy_q;
	logic [TW-1:0] tex_q [4];
	logic [TW-1:0] r0_q, r1_q, bil0_q, res_q;
	logic [mbtl_pkg::OUT_W-1:0] out_q;

	// fetch address unit
	logic [LVW-1:0] f_lvl;
	logic signed [CW-1:0] f_s, f_t, s_w, t_w;
	logic [LVW-1:0] f_lsw, f_lsh;
	logic [CW-1:0] mask_w, mask_h;
	logic s_out, t_out, f_black;
	logic [AW-1:0] f_addr;

	always_comb begin
		case (cmd.code)
			mbtl_pkg::CMD_B_RD: begin
				f_lvl = blvl_q - LVW'(1);
				f_s = $signed(CW'({bs_q, k_q[0]}));
				f_t = $signed(CW'({bt_q, k_q[1]}));
			end
			mbtl_pkg::CMD_TOP: begin
				f_lvl = top;
				f_s = '0;
				f_t = '0;
			end
			default: begin
				f_lvl = cur_lvl_q;
				f_s = ix_q + $signed({{(CW - 1){1'b0}}, k_q[0]});
				f_t = iy_q + $signed({{(CW - 1){1'b0}}, k_q[1]});
			end
		endcase
	end

	assign f_lsw = mbtl_pkg::side_log(lgw, f_lvl);
	assign f_lsh = mbtl_pkg::side_log(lgh, f_lvl);
	assign mask_w = ~({CW{1'b1}} << f_lsw);
	assign mask_h = ~({CW{1'b1}} << f_lsh);
	assign s_out = (f_s < 0) || (f_s > $signed(mask_w));
	assign t_out = (f_t < 0) || (f_t > $signed(mask_h));

	// edge handling
	always_comb begin
		f_black = 1'b0;
		case (wrap_q)
			mbtl_pkg::WRAP_REPEAT: begin
				s_w = f_s & $signed(mask_w);
				t_w = f_t & $signed(mask_h);
			end
			mbtl_pkg::WRAP_CLAMP: begin
				s_w = (f_s < 0) ? '0 : (s_out ? $signed(mask_w) : f_s);
				t_w = (f_t < 0) ? '0 : (t_out ? $signed(mask_h) : f_t);
			end
			default: begin
				s_w = f_s;
				t_w = f_t;
				f_black = s_out || t_out;
			end
		endcase
	end

	assign f_addr = lb_q[f_lvl[LW-1:0]] + (AW'(t_w[L-1:0]) << f_lsw) + AW'(s_w[L-1:0]);

	// pyramid memory
	logic [TW-1:0] mem [DEPTH];
	logic [TW-1:0] rdata_q;
	logic blk_q;
	logic mem_we, mem_re;
	logic [AW-1:0] waddr;
	logic [TW-1:0] wdata, fd;
	logic [TW+1:0] box_sum;

	assign box_sum = acc_q + (TW + 2)'(fd);
	assign mem_we = (cmd.code == mbtl_pkg::CMD_LOAD) || (cmd.code == mbtl_pkg::CMD_B_WR);
	assign mem_re = (cmd.code == mbtl_pkg::CMD_B_RD) || (cmd.code == mbtl_pkg::CMD_L_RD)
		|| (cmd.code == mbtl_pkg::CMD_TOP);
	assign waddr = (cmd.code == mbtl_pkg::CMD_LOAD) ? ld_addr : wptr_q;
	assign wdata = (cmd.code == mbtl_pkg::CMD_LOAD) ? TW'(texel_value) : box_sum[TW+1:2];
	assign fd = blk_q ? '0 : rdata_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[f_addr];
			blk_q <= f_black;
		end
	end

	// filter width and level
	logic [WW-1:0] abs_v [4];
	logic [WW-1:0] max01, max23, wmax;
	logic [4:0] lead;
	logic [WW+7:0] norm;
	logic signed [VW-1:0] lv;
	logic below, above;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			abs_v[i] = der_q[i][WW-1] ? WW'(-der_q[i]) : WW'(der_q[i]);
		end
	end
	assign max01 = (abs_v[0] > abs_v[1]) ? abs_v[0] : abs_v[1];
	assign max23 = (abs_v[2] > abs_v[3]) ? abs_v[2] : abs_v[3];
	assign wmax = (max01 > max23) ? max01 : max23;

	always_comb begin
		lead = '0;
		for (int i = 0; i < WW; i++) begin
			if (wmax_q[i]) begin
				lead = 5'(i);
			end
		end
	end
	assign norm = {wmax_q, 8'h00} >> lead;
	assign lv = $signed(VW'({top, 8'h00})) + $signed(VW'(norm[7:0]))
		+ $signed(VW'({lead, 8'h00})) - $signed(VW'(LV_BIAS));
	assign below = (wmax_q == '0) || (lv < 0);
	assign above = lv > $signed(VW'({top, 8'h00}));

	// sample position
	logic [LVW-1:0] p_ls_w, p_ls_h;
	logic signed [XW-1:0] px, py;
	assign p_ls_w = mbtl_pkg::side_log(lgw, cur_lvl_q);
	assign p_ls_h = mbtl_pkg::side_log(lgh, cur_lvl_q);
	assign px = (XW'(sc_q) <<< p_ls_w) - $signed(XW'(HALF));
	assign py = (XW'(tc_q) <<< p_ls_h) - $signed(XW'(HALF));

	// shared lerp: a + ((b - a) * f) >> 16
	logic [TW-1:0] la, lb;
	logic [FW-1:0] lf;
	logic signed [TW:0] ldiff;
	logic signed [TW+17:0] lprod, lsh;
	logic [TW-1:0] ly;

	always_comb begin
		case (cmd.code)
			mbtl_pkg::CMD_LR1: begin
				la = tex_q[2];
				lb = tex_q[3];
				lf = fx_q;
			end
			mbtl_pkg::CMD_LR2: begin
				la = r0_q;
				lb = r1_q;
				lf = fy_q;
			end
			mbtl_pkg::CMD_BLEND: begin
				la = bil0_q;
				lb = res_q;
				lf = {d_q, 8'h00};
			end
			default: begin
				la = tex_q[0];
				lb = tex_q[1];
				lf = fx_q;
			end
		endcase
	end
	assign ldiff = $signed({1'b0, lb}) - $signed({1'b0, la});
	assign lprod = ldiff * $signed({1'b0, lf});
	assign lsh = lprod >>> FW;
	assign ly = la + lsh[TW-1:0];

	// build level geometry
	logic [LVW-1:0] b_lsw, b_lsh;
	logic [L-1:0] bmask_w, bmask_h;
	assign b_lsw = mbtl_pkg::side_log(lgw, blvl_q);
	assign b_lsh = mbtl_pkg::side_log(lgh, blvl_q);
	assign bmask_w = ~({L{1'b1}} << b_lsw);
	assign bmask_h = ~({L{1'b1}} << b_lsh);

	assign st.k_last = (k_q == 2'd3);
	assign st.tex_last = (bs_q == bmask_w) && (bt_q == bmask_h);
	assign st.lvl_last = (blvl_q == top);
	assign st.mode_top = mode_top_q;
	assign st.mode_blend = mode_blend_q;
	assign st.which = which_q;

	// command execution
	always_ff @(posedge clk) begin
		case (cmd.code)
			mbtl_pkg::CMD_LATCH: begin
				sc_q <= s_coord;
				tc_q <= t_coord;
				der_q[0] <= ds_dx;
				der_q[1] <= dt_dx;
				der_q[2] <= ds_dy;
				der_q[3] <= dt_dy;
			end
			mbtl_pkg::CMD_ZERO: begin
				res_q <= '0;
			end
			mbtl_pkg::CMD_B_INIT: begin
				lb_q[0] <= '0;
				blvl_q <= LVW'(1);
				wptr_q <= total[AW-1:0];
			end
			mbtl_pkg::CMD_B_LVL: begin
				lb_q[blvl_q[LW-1:0]] <= wptr_q;
				bs_q <= '0;
				bt_q <= '0;
				k_q <= '0;
			end
			mbtl_pkg::CMD_B_RD: begin
				acc_q <= (k_q == 2'd0) ? '0 : box_sum;
				k_q <= k_q + 2'd1;
			end
			mbtl_pkg::CMD_B_WR: begin
				wptr_q <= wptr_q + AW'(1);
				k_q <= '0;
				if (st.tex_last) begin
					blvl_q <= blvl_q + LVW'(1);
				end else if (bs_q == bmask_w) begin
					bs_q <= '0;
					bt_q <= bt_q + L'(1);
				end else begin
					bs_q <= bs_q + L'(1);
				end
			end
			mbtl_pkg::CMD_L_MAX: begin
				wmax_q <= wmax;
			end
			mbtl_pkg::CMD_L_LVL: begin
				mode_top_q <= !below && above;
				mode_blend_q <= !below && !above && (lv[7:0] != 8'h00);
				cur_lvl_q <= below ? '0 : lv[LVW+7:8];
				d_q <= lv[7:0];
				which_q <= 1'b0;
			end
			mbtl_pkg::CMD_L_POS: begin
				ix_q <= px[XW-1:FW];
				iy_q <= py[XW-1:FW];
				fx_q <= px[FW-1:0];
				fy_q <= py[FW-1:0];
				k_q <= '0;
			end
			mbtl_pkg::CMD_L_RD: begin
				if (k_q != 2'd0) begin
					tex_q[k_q - 2'd1] <= fd;
				end
				k_q <= k_q + 2'd1;
			end
			mbtl_pkg::CMD_L_CAP: begin
				tex_q[3] <= fd;
			end
			mbtl_pkg::CMD_LR0: begin
				r0_q <= ly;
			end
			mbtl_pkg::CMD_LR1: begin
				r1_q <= ly;
			end
			mbtl_pkg::CMD_LR2: begin
				if (!which_q) begin
					bil0_q <= ly;
				end
				res_q <= ly;
			end
			mbtl_pkg::CMD_NEXT: begin
				which_q <= 1'b1;
				cur_lvl_q <= cur_lvl_q + LVW'(1);
			end
			mbtl_pkg::CMD_BLEND: begin
				res_q <= ly;
			end
			mbtl_pkg::CMD_TOPC: begin
				res_q <= fd;
			end
			mbtl_pkg::CMD_OUT: begin
				out_q <= mbtl_pkg::OUT_W'(res_q);
			end
			default: begin
			end
		endcase
	end

	assign filtered_value = out_q;

endmodule

/* rtl/mipmap_build_trilinear_lookup_unit.sv */
// top level of the mipmap pyramid builder with trilinear lookup
// Base texels are loaded one item per cycle while idle, in raster order, s fastest. The item
// that completes the base image starts a build pass that the block runs on its own, with the
// input stalled: each pyramid texel takes four reads of the single-read-port store and one
// write, and each level opens with its own setup state. A lookup takes one item and runs
// through the one shared read port and lerp unit in one of four ways: a bilinear fetch on one
// level, two such fetches blended across two levels, a read of the top texel, or an answer
// of 0 for a lookup made before any pyramid exists. The result sits in an output register,
// so a new item is taken while it waits. Configuration must be written while the block is
// idle, which the block itself does not enforce; a size write discards the loaded image.
module mipmap_build_trilinear_lookup_unit #(
	parameter int LOG_MAX_SIDE = mbtl_pkg::DEF_LOG_MAX_SIDE,
	parameter int TEXEL_BITS = mbtl_pkg::DEF_TEXEL_BITS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic op,
	input  logic [mbtl_pkg::TEXIN_W-1:0] texel_value,
	input  logic signed [mbtl_pkg::COORD_W-1:0] s_coord,
	input  logic signed [mbtl_pkg::COORD_W-1:0] t_coord,
	input  logic signed [mbtl_pkg::COORD_W-1:0] ds_dx,
	input  logic signed [mbtl_pkg::COORD_W-1:0] dt_dx,
	input  logic signed [mbtl_pkg::COORD_W-1:0] ds_dy,
	input  logic signed [mbtl_pkg::COORD_W-1:0] dt_dy,
	output logic out_valid,
	input  logic out_stall,
	output logic [mbtl_pkg::OUT_W-1:0] filtered_value,
	input  logic cfg_we,
	input  logic [mbtl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mbtl_pkg::CFG_W-1:0] cfg_data
);

	mbtl_pkg::cmd_t cmd;
	mbtl_pkg::status_t st;

	// sequencer
	mbtl_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.st(st),
		.cmd(cmd)
	);

	// store and arithmetic
	mbtl_dp #(
		.LOG_MAX_SIDE(LOG_MAX_SIDE),
		.TEXEL_BITS(TEXEL_BITS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.st(st),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.texel_value(texel_value),
		.s_coord(s_coord),
		.t_coord(t_coord),
		.ds_dx(ds_dx),
		.dt_dx(dt_dx),
		.ds_dy(ds_dy),
		.dt_dy(dt_dy),
		.filtered_value(filtered_value)
	);

endmodule

/* test/mipmap_build_trilinear_lookup_unit_tb.sv */
// testbench of the mipmap pyramid builder with trilinear lookup, self-checking against a predictor
module mipmap_build_trilinear_lookup_unit_tb;

	localparam int LMAX = mbtl_pkg::DEF_LOG_MAX_SIDE;
	localparam int TEX_DEPTH = ((1 << (2 * LMAX + 2)) - 1) / 3 + 1;
	localparam logic [1:0] WRAP_BLACK = 2'd2;
	localparam logic [1:0] WRAP_SPARE = 2'd3;
	localparam logic [mbtl_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;
	localparam int BUILD_WAIT = 3000;
	localparam int HOLD_CYCLES = 400;
	localparam int WATCH_LIMIT = 20000;

	typedef struct {
		logic op;
		logic [15:0] texel;
		logic signed [19:0] s, t, sx, tx, sy, ty;
		bit typed;
		logic [15:0] want;
	} stim_t;

	logic clk = 0, arst_n = 0;
	logic in_valid = 0, in_stall, op = 0, out_valid, out_stall = 0, cfg_we = 0;
	logic [15:0] texel_value = 0, filtered_value;
	logic signed [19:0] s_coord = 0, t_coord = 0, ds_dx = 0, dt_dx = 0, ds_dy = 0, dt_dy = 0;
	logic [mbtl_pkg::CFG_IDX_W-1:0] cfg_index = 0;
	logic [mbtl_pkg::CFG_W-1:0] cfg_data = 0;

	mipmap_build_trilinear_lookup_unit u_dut (.*);

	// clock
	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	// predictor state
	logic [15:0] tex_mem [0:TEX_DEPTH-1];
	int lvl_base [0:LMAX];
	int ld_count;
	bit pyr_ready;
	int wrap_sel, lg_w, lg_h;
	logic [15:0] filt_q [$];
	int send_idle_pct = 0, stall_pct = 0, hold_left = 0;
	bit failed = 0;
	int quiet_cycles = 0;

	function automatic int eff(int v);
		return v > LMAX ? LMAX : v;
	endfunction

	function automatic int side(int lg, int lvl);
		return lvl >= lg ? 1 : (1 << (lg - lvl));
	endfunction

	function automatic int nlev();
		int a, b;
		a = eff(lg_w);
		b = eff(lg_h);
		return 1 + (a > b ? a : b);
	endfunction

	function automatic longint texel_at(int lvl, longint s, longint t);
		longint w, h, idx;
		w = side(eff(lg_w), lvl);
		h = side(eff(lg_h), lvl);
		if (wrap_sel == mbtl_pkg::WRAP_REPEAT) begin
			s = s & (w - 1);
			t = t & (h - 1);
		end else if (wrap_sel == mbtl_pkg::WRAP_CLAMP) begin
			s = s < 0 ? 0 : (s > w - 1 ? w - 1 : s);
			t = t < 0 ? 0 : (t > h - 1 ? h - 1 : t);
		end else if (s < 0 || s > w - 1 || t < 0 || t > h - 1) begin
			return 0;
		end
		idx = lvl_base[lvl] + t * w + s;
		if (idx >= TEX_DEPTH) return 0;
		return tex_mem[idx];
	endfunction

	function automatic longint mix16(longint a, longint b, longint f);
		return (a * (65536 - f) + b * f) >>> 16;
	endfunction

	function automatic longint bilin(int lvl, longint sc, longint tc);
		longint w, h, x, y, ix, iy, fx, fy, r0, r1;
		if (lvl > nlev() - 1) lvl = nlev() - 1;
		w = side(eff(lg_w), lvl);
		h = side(eff(lg_h), lvl);
		x = sc * w - 32768;
		y = tc * h - 32768;
		ix = x >>> 16;
		iy = y >>> 16;
		fx = x & 16'hFFFF;
		fy = y & 16'hFFFF;
		r0 = mix16(texel_at(lvl, ix, iy), texel_at(lvl, ix + 1, iy), fx);
		r1 = mix16(texel_at(lvl, ix, iy + 1), texel_at(lvl, ix + 1, iy + 1), fx);
		return mix16(r0, r1, fy);
	endfunction

	// downsample every level from the one below
	function automatic void build_levels();
		int lw, lh, n, w, h;
		longint sum;
		lw = eff(lg_w);
		lh = eff(lg_h);
		n = nlev();
		lvl_base[0] = 0;
		for (int i = 1; i < n; i++) begin
			w = side(lw, i);
			h = side(lh, i);
			lvl_base[i] = lvl_base[i-1] + side(lw, i - 1) * side(lh, i - 1);
			for (int t = 0; t < h; t++)
				for (int s = 0; s < w; s++) begin
					sum = texel_at(i - 1, 2 * s, 2 * t) + texel_at(i - 1, 2 * s + 1, 2 * t)
						+ texel_at(i - 1, 2 * s, 2 * t + 1)
						+ texel_at(i - 1, 2 * s + 1, 2 * t + 1);
					if (lvl_base[i] + t * w + s < TEX_DEPTH)
						tex_mem[lvl_base[i] + t * w + s] = 16'(sum >> 2);
				end
		end
	endfunction

	function automatic longint trilinear(stim_t it);
		longint sc, tc, w, v, lvl, top, frac, a, b, d;
		longint dv [4];
		int p;
		sc = it.s;
		tc = it.t;
		dv = '{it.sx, it.tx, it.sy, it.ty};
		top = nlev() - 1;
		w = 0;
		foreach (dv[i]) begin
			v = dv[i] < 0 ? -dv[i] : dv[i];
			if (v > w) w = v;
		end
		if (w == 0) return bilin(0, sc, tc);
		p = 0;
		for (int i = 20; i >= 0; i--)
			if (w[i]) begin
				p = i;
				break;
			end
		frac = p >= 8 ? (w >> (p - 8)) & 255 : (w << (8 - p)) & 255;
		lvl = top * 256 + (p - 16) * 256 + frac;
		if (lvl < 0) return bilin(0, sc, tc);
		if (lvl > top * 256) return texel_at(int'(top), 0, 0);
		d = lvl & 255;
		a = bilin(int'(lvl / 256), sc, tc);
		b = bilin(int'(lvl / 256) + 1, sc, tc);
		return (a * (256 - d) + b * d) >> 8;
	endfunction

	// apply one accepted item to the predictor
	function automatic void predict(stim_t it);
		int total;
		if (it.op == mbtl_pkg::OP_LOAD) begin
			total = side(eff(lg_w), 0) * side(eff(lg_h), 0);
			if (pyr_ready) begin
				pyr_ready = 0;
				ld_count = 0;
			end
			if (ld_count < TEX_DEPTH) tex_mem[ld_count] = it.texel;
			ld_count++;
			if (ld_count >= total) begin
				build_levels();
				pyr_ready = 1;
				ld_count = 0;
			end
		end else if (it.typed) begin
			filt_q.push_back(it.want);
		end else begin
			filt_q.push_back(pyr_ready ? 16'(trilinear(it)) : 16'd0);
		end
	endfunction

	task automatic cfg_write(logic [mbtl_pkg::CFG_IDX_W-1:0] idx,
			logic [mbtl_pkg::CFG_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 0;
		if (idx == mbtl_pkg::REG_WRAP) begin
			wrap_sel = val[1:0];
		end else if (idx == mbtl_pkg::REG_LOG_W || idx == mbtl_pkg::REG_LOG_H) begin
			if (idx == mbtl_pkg::REG_LOG_W) lg_w = val;
			else lg_h = val;
			ld_count = 0;
			pyr_ready = 0;
		end
	endtask

	// offer one item and wait for it to be taken
	task automatic send(stim_t it);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1;
		op <= it.op;
		texel_value <= it.texel;
		s_coord <= it.s;
		t_coord <= it.t;
		ds_dx <= it.sx;
		dt_dx <= it.tx;
		ds_dy <= it.sy;
		dt_dy <= it.ty;
		do @(posedge clk); while (in_stall);
		predict(it);
	endtask

	// let every result arrive, then cover a build pass still running
	task automatic drain();
		@(negedge clk);
		in_valid <= 0;
		while (filt_q.size() != 0) @(posedge clk);
		repeat (BUILD_WAIT) @(posedge clk);
	endtask

	function automatic stim_t row(logic o, logic [15:0] tx, logic signed [19:0] s,
			logic signed [19:0] t, logic signed [19:0] d, bit typed = 0,
			logic [15:0] want = 0);
		stim_t r;
		r = '{o, tx, s, t, d, -d, 20'sd0, 20'sd0, typed, want};
		return r;
	endfunction

	function automatic logic signed [19:0] rand_deriv();
		int p;
		logic signed [19:0] v;
		case ($urandom_range(0, 3))
			0: v = 20'($urandom);
			1: v = 0;
			2: begin
				p = $urandom_range(4, 18);
				v = 20'((1 << p) | ($urandom & ((1 << p) - 1)));
				if ($urandom_range(0, 1)) v = -v;
			end
			default: v = 20'($urandom_range(0, 511)) - 20'sd256;
		endcase
		return v;
	endfunction

	function automatic logic signed [19:0] rand_coord();
		return $urandom_range(0, 3) == 0 ? 20'($urandom)
			: 20'($urandom_range(0, 262143)) - 20'sd131072;
	endfunction

	function automatic stim_t rand_item(logic o);
		stim_t r;
		r.op = o;
		r.texel = $urandom_range(0, 9) == 0 ? ($urandom_range(0, 1) ? 16'hFFFF : 16'h0)
			: 16'($urandom);
		r.s = rand_coord();
		r.t = rand_coord();
		r.sx = rand_deriv();
		r.tx = rand_deriv();
		r.sy = rand_deriv();
		r.ty = rand_deriv();
		r.typed = 0;
		return r;
	endfunction

	// receiver stall, with a long hold-off on request
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1;
			hold_left--;
		end else begin
			out_stall <= $urandom_range(0, 99) < stall_pct;
		end
	end

	// result check
	always @(posedge clk) begin
		logic [15:0] exp_val;
		if (arst_n && out_valid && !out_stall) begin
			if (filt_q.size() == 0) begin
				$error("filtered_value: unexpected item, actual %h", filtered_value);
				failed = 1;
			end else begin
				exp_val = filt_q.pop_front();
				if (filtered_value !== exp_val) begin
					$error("filtered_value: expected %h, actual %h", exp_val, filtered_value);
					failed = 1;
				end
			end
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
		else quiet_cycles++;
		if (quiet_cycles >= WATCH_LIMIT) begin
			$display("mipmap_build_trilinear_lookup_unit_tb: done, errors");
			$finish;
		end
	end

	initial begin
		stim_t dir_tab [$];
		int phase_cfg [8][3] = '{'{mbtl_pkg::WRAP_REPEAT, 2, 2}, '{mbtl_pkg::WRAP_CLAMP, 3, 1},
			'{WRAP_BLACK, 0, 0}, '{WRAP_SPARE, 2, 3}, '{mbtl_pkg::WRAP_REPEAT, 15, 0},
			'{WRAP_BLACK, 0, 8}, '{mbtl_pkg::WRAP_CLAMP, 4, 4}, '{mbtl_pkg::WRAP_REPEAT, 1, 3}};
		int total, n_look;

		ld_count = 0;
		pyr_ready = 0;
		wrap_sel = mbtl_pkg::WRAP_REPEAT;
		lg_w = 8;
		lg_h = 8;
		repeat (11) @(negedge clk);
		arst_n = 1;

		// directed: 2x2 image under clamp
		cfg_write(mbtl_pkg::REG_WRAP, mbtl_pkg::WRAP_CLAMP);
		cfg_write(mbtl_pkg::REG_LOG_W, 4'd1);
		cfg_write(mbtl_pkg::REG_LOG_H, 4'd1);
		cfg_write(REG_SPARE, 4'hF);
		dir_tab.push_back(row(mbtl_pkg::OP_LOOKUP, 0, 20'sd32768, 20'sd32768, 20'sd0, 1, 16'h0));
		dir_tab.push_back(row(mbtl_pkg::OP_LOAD, 16'hFFFF, 0, 0, 0));
		dir_tab.push_back(row(mbtl_pkg::OP_LOAD, 16'h0000, 0, 0, 0));
		dir_tab.push_back(row(mbtl_pkg::OP_LOAD, 16'hFFFF, 0, 0, 0));
		dir_tab.push_back(row(mbtl_pkg::OP_LOAD, 16'h0000, 0, 0, 0));
		dir_tab.push_back(row(mbtl_pkg::OP_LOOKUP, 0, 20'sd0, 20'sd0, 20'sh7FFFF, 1, 16'h7FFF));
		dir_tab.push_back(row(mbtl_pkg::OP_LOOKUP, 0, 20'sd0, 20'sd0, -20'sh80000, 1, 16'h7FFF));
		dir_tab.push_back(row(mbtl_pkg::OP_LOOKUP, 0, 20'sd16384, 20'sd16384, 20'sd0));
		dir_tab.push_back(row(mbtl_pkg::OP_LOOKUP, 0, 20'sh7FFFF, -20'sh80000, 20'sd0));
		dir_tab.push_back(row(mbtl_pkg::OP_LOOKUP, 0, -20'sh80000, 20'sh7FFFF, 20'sd1));
		dir_tab.push_back(row(mbtl_pkg::OP_LOOKUP, 0, 20'sd49152, 20'sd20000, 20'sd49152));
		dir_tab.push_back(row(mbtl_pkg::OP_LOOKUP, 0, 20'sd30000, 20'sd40000, 20'sd32768));
		dir_tab.push_back(row(mbtl_pkg::OP_LOOKUP, 0, 20'sd30000, 20'sd40000, 20'sd65536));
		dir_tab.push_back(row(mbtl_pkg::OP_LOOKUP, 0, 20'sd30000, 20'sd40000, 20'sd65537));
		dir_tab.push_back(row(mbtl_pkg::OP_LOOKUP, 0, 20'sd70000, -20'sd5000, 20'sd40000));
		dir_tab.push_back(row(mbtl_pkg::OP_LOAD, 16'h1234, 0, 0, 0));
		dir_tab.push_back(row(mbtl_pkg::OP_LOOKUP, 0, 20'sd32768, 20'sd32768, 20'sd0, 1, 16'h0));
		dir_tab.push_back(row(mbtl_pkg::OP_LOAD, 16'h8000, 0, 0, 0));
		dir_tab.push_back(row(mbtl_pkg::OP_LOAD, 16'h0001, 0, 0, 0));
		dir_tab.push_back(row(mbtl_pkg::OP_LOAD, 16'h7FFE, 0, 0, 0));
		dir_tab.push_back(row(mbtl_pkg::OP_LOOKUP, 0, 20'sd10000, 20'sd60000, 20'sd50000));
		foreach (dir_tab[i]) send(dir_tab[i]);
		drain();

		// random phases over several sizes and wrap modes
		for (int ph = 0; ph < 8; ph++) begin
			send_idle_pct = 0;
			stall_pct = 0;
			cfg_write(mbtl_pkg::REG_WRAP, mbtl_pkg::CFG_W'(phase_cfg[ph][0]));
			cfg_write(mbtl_pkg::REG_LOG_W, mbtl_pkg::CFG_W'(phase_cfg[ph][1]));
			cfg_write(mbtl_pkg::REG_LOG_H, mbtl_pkg::CFG_W'(phase_cfg[ph][2]));
			case (ph % 4)
				1: send_idle_pct = 74;
				2: stall_pct = 74;
				3: begin
					send_idle_pct = 17;
					stall_pct = 17;
				end
				default: ;
			endcase
			total = side(eff(phase_cfg[ph][1]), 0) * side(eff(phase_cfg[ph][2]), 0);
			n_look = total > 150 ? 40 : 165 - total;
			for (int k = 0; k < total; k++) send(rand_item(mbtl_pkg::OP_LOAD));
			for (int k = 0; k < n_look; k++) begin
				if (ph == 2 && k == 20) hold_left = HOLD_CYCLES;
				if (ph == 5 && k == 30) drain();
				send(rand_item($urandom_range(0, 19) == 0 ? mbtl_pkg::OP_LOAD
					: mbtl_pkg::OP_LOOKUP));
			end
			drain();
		end

		if (!failed) begin
			$display("mipmap_build_trilinear_lookup_unit_tb: done, clean");
		end else begin
			$display("mipmap_build_trilinear_lookup_unit_tb: done, errors");
		end
		$finish;
	end

endmodule
